@@ hdl/ircf_pkg.sv @@
// Shared constants, register codes and types of the iterated ripple comb filter.
package ircf_pkg;

    localparam int MAX_STAGES_DEF  = 16;
    localparam int MAX_DELAY_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int OUT_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int ITER_W     = 5;
    localparam int DELAY_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd3;

    localparam logic signed [GAIN_W-1:0] GAIN_POS_MAX = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] GAIN_NEG_MAX = -16'sd16384;

    localparam logic signed [OUT_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] S24_MIN = 24'sh800000;

    // Per-item controls handed to the stage arithmetic.
    typedef struct packed {
        logic add_same;
        logic zero_delay;
        logic hist_ok;
    } t_alu_ctl;

endpackage

@@ hdl/ircf_hist_mem.sv @@
// Stage history memory: one write port and one registered read port.
module ircf_hist_mem
    import ircf_pkg::*;
#(
    parameter int AW = 14
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [OUT_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [OUT_W-1:0] o_rdata
);

    logic [OUT_W-1:0] r_mem [0:(1 << AW)-1];
    logic [OUT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ircf_stage_alu.sv @@
// One delay-and-add stage: rounded gain product plus base, saturated to 24 bits.
module ircf_stage_alu
    import ircf_pkg::*;
(
    input  t_alu_ctl                 i_ctl,
    input  logic signed [OUT_W-1:0]  i_x,
    input  logic signed [OUT_W-1:0]  i_s,
    input  logic signed [OUT_W-1:0]  i_hist,
    input  logic signed [GAIN_W-1:0] i_gain,
    output logic signed [OUT_W-1:0]  o_s,
    output logic                     o_clip
);

    localparam int PW = OUT_W + GAIN_W;
    localparam int TW = PW - 14;

    logic signed [OUT_W-1:0] h;
    logic signed [OUT_W-1:0] base;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    rounded;
    logic signed [TW-1:0]    term;
    logic signed [TW-1:0]    sum;

    always_comb begin
        if (i_ctl.zero_delay) begin
            h = i_s;
        end else if (i_ctl.hist_ok) begin
            h = i_hist;
        end else begin
            h = '0;
        end
        base    = i_ctl.add_same ? i_s : i_x;
        prod    = PW'(h) * PW'(i_gain);
        rounded = prod + PW'(8192);
        // Floor shift gives round to nearest with ties toward plus infinity.
        term    = rounded[PW-1:14];
        sum     = TW'(base) + term;
        if (sum > TW'(S24_MAX)) begin
            o_s    = S24_MAX;
            o_clip = 1'b1;
        end else if (sum < TW'(S24_MIN)) begin
            o_s    = S24_MIN;
            o_clip = 1'b1;
        end else begin
            o_s    = sum[OUT_W-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

@@ hdl/iterated_ripple_comb_filter.sv @@
// Top level of the iterated ripple comb filter: control, history pointers and output register.
// The result is loaded after the last stage, or held pending while the output is stalled.
// The input stays stalled until an item has passed all stages and its result is loaded; the
// single shared stage unit takes one history read, multiply-add and history write per stage.
// Reset is synchronous and active low; it clears control and pointers and returns the
// configuration to its defaults. The history memory is not cleared; reads are gated instead.
module iterated_ripple_comb_filter
    import ircf_pkg::*;
#(
    parameter int MAX_STAGES  = MAX_STAGES_DEF,
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_signal_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [OUT_W-1:0]       o_sample_out,
    output logic                          o_saturated
);

    // Address bits of one history ring, stage index bits and sample count bits.
    localparam int DAW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int SW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CW  = $clog2(MAX_DELAY + 1);
    localparam int AW  = SW + DAW;

    // Configuration registers.
    logic                     r_mode;
    logic [ITER_W-1:0]        r_iter;
    logic [DELAY_W-1:0]       r_delay;
    logic signed [GAIN_W-1:0] r_gain;

    // Control state.
    logic          r_busy;
    logic          r_pend;
    logic          r_out_valid;
    logic [DAW-1:0] r_wp;
    logic [CW-1:0]  r_cnt;

    // Per-item working registers.
    logic [SW-1:0]           r_stg;
    logic [SW-1:0]           r_last_act;
    logic [DAW-1:0]          r_rp;
    logic [DAW-1:0]          r_wslot;
    t_alu_ctl                r_ctl;
    logic signed [OUT_W-1:0] r_x;
    logic signed [OUT_W-1:0] r_s;
    logic signed [OUT_W-1:0] r_res;
    logic                    r_sat;
    logic signed [OUT_W-1:0] r_out_sample;
    logic                    r_out_sat;

    logic signed [OUT_W-1:0] x24;
    logic [DAW-1:0]          d_eff;
    logic [DAW-1:0]          rp;
    logic [DAW-1:0]          n_wp;
    logic [CW-1:0]           cnt_eff;
    logic [CW-1:0]           n_cnt;
    logic [SW-1:0]           last_act;
    logic                    accept_in;
    logic                    out_free;
    logic                    last_stg;
    logic                    active;
    logic                    load_last;
    logic                    load_pend;
    logic [SW-1:0]           stg_nxt;
    logic signed [OUT_W-1:0] s_new;
    logic                    clip;
    logic signed [OUT_W-1:0] n_res;
    logic                    n_sat;
    logic signed [GAIN_W-1:0] gain_wr;
    t_alu_ctl                ctl_in;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic [OUT_W-1:0]        rdata;

    // Bring the input sample to 24 bits; a wider sample is clamped without flagging.
    if (SAMPLE_BITS > OUT_W) begin : g_wide_in
        localparam logic signed [SAMPLE_BITS-1:0] IN_MAX = SAMPLE_BITS'(S24_MAX);
        localparam logic signed [SAMPLE_BITS-1:0] IN_MIN = SAMPLE_BITS'(S24_MIN);
        always_comb begin
            if (i_sample_in > IN_MAX) begin
                x24 = S24_MAX;
            end else if (i_sample_in < IN_MIN) begin
                x24 = S24_MIN;
            end else begin
                x24 = i_sample_in[OUT_W-1:0];
            end
        end
    end else begin : g_narrow_in
        assign x24 = OUT_W'(i_sample_in);
    end

    assign o_in_stall = r_busy || r_pend;
    assign accept_in  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Item setup: clamp the delay and stage count, find the read slot and the history gate.
    always_comb begin
        if (32'(r_delay) > 32'(MAX_DELAY - 1)) begin
            d_eff = DAW'(MAX_DELAY - 1);
        end else begin
            d_eff = DAW'(r_delay);
        end
        if (r_wp >= d_eff) begin
            rp = r_wp - d_eff;
        end else begin
            rp = DAW'(32'(r_wp) + MAX_DELAY - 32'(d_eff));
        end
        if (r_wp == DAW'(MAX_DELAY - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + DAW'(1);
        end
        // A new signal discards the history before this sample.
        cnt_eff = i_signal_start ? '0 : r_cnt;
        if (32'(cnt_eff) < 32'(MAX_DELAY)) begin
            n_cnt = cnt_eff + CW'(1);
        end else begin
            n_cnt = cnt_eff;
        end
        if (r_iter == '0) begin
            last_act = '0;
        end else if (32'(r_iter) > 32'(MAX_STAGES)) begin
            last_act = SW'(MAX_STAGES - 1);
        end else begin
            last_act = SW'(r_iter - ITER_W'(1));
        end
        ctl_in.add_same   = r_mode;
        ctl_in.zero_delay = (d_eff == '0);
        ctl_in.hist_ok    = (32'(cnt_eff) >= 32'(d_eff));
    end

    // Stage sequencing. Every stage updates its ring, but only the active ones
    // set the result and the clip flag.
    assign last_stg  = r_busy && (r_stg == SW'(MAX_STAGES - 1));
    assign active    = (r_stg <= r_last_act);
    assign stg_nxt   = SW'({1'b0, r_stg} + (SW + 1)'(1));
    assign n_res     = active ? s_new : r_res;
    assign n_sat     = r_sat | (active & clip);
    assign load_last = last_stg && out_free;
    assign load_pend = r_pend && out_free;

    // The next stage's history word is fetched while this stage computes.
    assign raddr = accept_in ? {SW'(0), rp} : {stg_nxt, r_rp};
    assign waddr = {r_stg, r_wslot};

    ircf_hist_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (waddr),
        .i_wdata (r_s),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ircf_stage_alu u_alu (
        .i_ctl  (r_ctl),
        .i_x    (r_x),
        .i_s    (r_s),
        .i_hist (rdata),
        .i_gain (r_gain),
        .o_s    (s_new),
        .o_clip (clip)
    );

    // Gain writes beyond plus or minus one saturate.
    always_comb begin
        if ($signed(i_cfg_data) > GAIN_POS_MAX) begin
            gain_wr = GAIN_POS_MAX;
        end else if ($signed(i_cfg_data) < GAIN_NEG_MAX) begin
            gain_wr = GAIN_NEG_MAX;
        end else begin
            gain_wr = $signed(i_cfg_data);
        end
    end

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_iter      <= ITER_W'(2);
            r_delay     <= '0;
            r_gain      <= GAIN_POS_MAX;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    CFG_ITER: begin
                        r_iter <= i_cfg_data[ITER_W-1:0];
                    end
                    CFG_DELAY: begin
                        r_delay <= i_cfg_data[DELAY_W-1:0];
                    end
                    CFG_GAIN: begin
                        r_gain <= gain_wr;
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
            if (accept_in) begin
                r_busy <= 1'b1;
                r_wp   <= n_wp;
                r_cnt  <= n_cnt;
            end else if (last_stg) begin
                r_busy <= 1'b0;
                r_pend <= !out_free;
            end else if (load_pend) begin
                r_pend <= 1'b0;
            end
            if (load_last || load_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_stg      <= '0;
            r_last_act <= last_act;
            r_rp       <= rp;
            r_wslot    <= r_wp;
            r_ctl      <= ctl_in;
            r_x        <= x24;
            r_s        <= x24;
            r_res      <= x24;
            r_sat      <= 1'b0;
        end else if (r_busy) begin
            r_stg <= stg_nxt;
            r_s   <= s_new;
            r_res <= n_res;
            r_sat <= n_sat;
        end
        if (load_last) begin
            r_out_sample <= n_res;
            r_out_sat    <= n_sat;
        end else if (load_pend) begin
            r_out_sample <= r_res;
            r_out_sat    <= r_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

endmodule

@@ hdl/ircf_checker.sv @@
// Port-level checks of the iterated ripple comb filter and their bind.
module ircf_checker
    import ircf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [OUT_W-1:0] o_sample_out,
    input logic                    o_saturated
);

    // Reset leaves the block empty and ready for a transfer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

    // One item at a time: an input transfer closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second input transfer while an item is in work");

    // No result can appear in the cycle right after an input transfer.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sample_out) && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind iterated_ripple_comb_filter ircf_checker u_ircf_checker (.*);
